// ===== hdl/text_console_char_writer_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Text console char writer - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_UNIT_DEFINES_SVH

// same-cycle implication
`define TCW_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/tcw_pkg.sv =====
// ---------------------------------------------------------------------------
// Text console char writer - package
// Beat types, character codes and screen geometry defaults.
// ---------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;
  localparam int CELL_W      = 11;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [7:0]        char_code;
    logic [CELL_W-1:0] cell_index;
  } in_beat_t;

  typedef struct packed {
    logic [CELL_W-1:0] cursor_cell;
    logic [7:0]        cell_char;
    logic              scrolled;
  } out_beat_t;

  typedef struct packed {
    logic write;
    logic wrap;
  } put_status_t;

endpackage

// ===== hdl/text_console_char_writer_unit.sv =====
// ---------------------------------------------------------------------------
// Text console char writer - top level
// A put result is registered directly; a valid read passes the registered memory
// read and the S_READ state. Items are held off during S_READ and while stalled.
// A scroll holds the block: row copy through the screen memory at one cell a
// cycle, then bottom-row clear. After reset a clearing pass fills the screen
// with spaces; no item is accepted until it ends. Cursor resets to cell 0.
// ---------------------------------------------------------------------------
module text_console_char_writer_unit #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tcw_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tcw_pkg::out_beat_t out_data
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int LAST  = CELLS - COLUMNS;
  localparam int AW    = $clog2(CELLS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_COPY  = 3'd3;
  localparam logic [2:0] S_FILL  = 3'd4;

  logic [2:0]    state;
  logic [AW-1:0] cnt;
  logic          cp_wr;
  logic [AW-1:0] cp_addr;

  logic          accept, put, rd_ok;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  logic [AW-1:0] cursor, cursor_next, put_addr;
  logic [7:0]    put_data;
  put_status_t   status;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign put      = accept && (in_data.kind == KIND_PUT);
  assign rd_ok    = 32'(in_data.cell_index) < 32'(CELLS);

  tcw_cursor #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS),
    .AW     (AW)
  ) u_cursor (
    .clk        (clk),
    .rst        (rst),
    .put        (put),
    .char_code  (in_data.char_code),
    .cursor     (cursor),
    .cursor_next(cursor_next),
    .wr_addr    (put_addr),
    .wr_data    (put_data),
    .status     (status)
  );

  tcw_screen_mem #(
    .DEPTH(CELLS),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    we    = 1'b0;
    waddr = cnt;
    wdata = CHAR_SPACE;
    re    = 1'b0;
    raddr = AW'(in_data.cell_index);
    case (state)
      S_CLEAR, S_FILL: begin
        we = 1'b1;
      end
      S_IDLE: begin
        we    = put && status.write;
        waddr = put_addr;
        wdata = put_data;
        re    = accept && (in_data.kind == KIND_READ) && rd_ok;
      end
      S_COPY: begin
        re    = cnt != AW'(LAST);
        raddr = cnt + AW'(COLUMNS);
        we    = cp_wr;
        waddr = cp_addr;
        wdata = rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      cp_wr     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          cnt <= cnt + AW'(1);
          if (cnt == AW'(CELLS - 1)) begin
            state <= S_IDLE;
            cnt   <= '0;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (in_data.kind == KIND_READ) begin
              if (rd_ok) begin
                state <= S_READ;
              end else begin
                out_valid <= 1'b1;
                out_data  <= '{cursor_cell: CELL_W'(cursor), cell_char: 8'h00,
                               scrolled: 1'b0};
              end
            end else if (status.wrap) begin
              state <= S_COPY;
              cnt   <= '0;
              cp_wr <= 1'b0;
            end else begin
              out_valid <= 1'b1;
              out_data  <= '{cursor_cell: CELL_W'(cursor_next), cell_char: 8'h00,
                             scrolled: 1'b0};
            end
          end
        end
        S_READ: begin
          state     <= S_IDLE;
          out_valid <= 1'b1;
          out_data  <= '{cursor_cell: CELL_W'(cursor), cell_char: rdata, scrolled: 1'b0};
        end
        S_COPY: begin
          if (cnt != AW'(LAST)) begin
            cnt     <= cnt + AW'(1);
            cp_wr   <= 1'b1;
            cp_addr <= cnt;
          end else begin
            cp_wr <= 1'b0;
            state <= S_FILL;
          end
        end
        S_FILL: begin
          cnt <= cnt + AW'(1);
          if (cnt == AW'(CELLS - 1)) begin
            state     <= S_IDLE;
            cnt       <= '0;
            out_valid <= 1'b1;
            out_data  <= '{cursor_cell: CELL_W'(cursor), cell_char: 8'h00,
                           scrolled: 1'b1};
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/tcw_screen_mem.sv =====
// ---------------------------------------------------------------------------
// Text console char writer - screen memory
// Character store, one write and one registered read port.
// ---------------------------------------------------------------------------
module tcw_screen_mem #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/tcw_cursor.sv =====
// ---------------------------------------------------------------------------
// Text console char writer - cursor unit
// Holds cursor, column and row start; works out the effect of one put.
// ---------------------------------------------------------------------------
module tcw_cursor #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  parameter int AW      = 11
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                put,
  input  logic [7:0]          char_code,
  output logic [AW-1:0]       cursor,
  output logic [AW-1:0]       cursor_next,
  output logic [AW-1:0]       wr_addr,
  output logic [7:0]          wr_data,
  output tcw_pkg::put_status_t status
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int LAST  = CELLS - COLUMNS;
  localparam int COLW  = $clog2(COLUMNS);

  logic [COLW-1:0] col, col_next;
  logic [AW-1:0]   row_start, row_start_next;

  always_comb begin
    cursor_next    = cursor;
    col_next       = col;
    row_start_next = row_start;
    wr_addr        = cursor;
    wr_data        = char_code;
    status         = '0;
    if (char_code == CHAR_LF) begin
      if (row_start == AW'(LAST)) begin
        status.wrap = 1'b1;
      end else begin
        cursor_next    = row_start + AW'(COLUMNS);
        row_start_next = row_start + AW'(COLUMNS);
        col_next       = '0;
      end
    end else if (char_code == CHAR_BS) begin
      status.write = 1'b1;
      wr_data      = CHAR_SPACE;
      if (col != '0) begin
        cursor_next = cursor - AW'(1);
        col_next    = col - COLW'(1);
        wr_addr     = cursor - AW'(1);
      end
    end else begin
      status.write = 1'b1;
      if (cursor == AW'(CELLS - 1)) begin
        status.wrap = 1'b1;
      end else if (col == COLW'(COLUMNS - 1)) begin
        cursor_next    = cursor + AW'(1);
        col_next       = '0;
        row_start_next = row_start + AW'(COLUMNS);
      end else begin
        cursor_next = cursor + AW'(1);
        col_next    = col + COLW'(1);
      end
    end
    if (status.wrap) begin
      cursor_next    = AW'(LAST);
      row_start_next = AW'(LAST);
      col_next       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor    <= '0;
      col       <= '0;
      row_start <= '0;
    end else if (put) begin
      cursor    <= cursor_next;
      col       <= col_next;
      row_start <= row_start_next;
    end
  end

endmodule

// ===== hdl/tcw_checker.sv =====
// ---------------------------------------------------------------------------
// Text console char writer - port checker
// Watches the top-level ports; bound to the top level below.
// ---------------------------------------------------------------------------
`include "text_console_char_writer_unit_defines.svh"

module tcw_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input tcw_pkg::in_beat_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input tcw_pkg::out_beat_t out_data
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELLS - COLUMNS);

  logic wide_screen;
  assign wide_screen = CELLS > (1 << CELL_W);

  `TCW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "output beat changed while stalled")
  `TCW_ASSERT_IMPL(a_cursor_range, out_valid, wide_screen || (32'(out_data.cursor_cell) < 32'(CELLS)), "cursor beyond screen")
  `TCW_ASSERT_IMPL(a_scroll_cursor, out_valid && out_data.scrolled, out_data.cursor_cell == LAST_CELL, "scroll did not leave cursor at last row start")
  `TCW_ASSERT_IMPL(a_scroll_no_char, out_valid && out_data.scrolled, out_data.cell_char == 8'h00, "scrolled beat carries a character")

endmodule

bind text_console_char_writer_unit tcw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tcw_checker (.*);
